// ===== hw/rtl/fdcc_pkg.sv =====
// Package with shared constants for the framed receiver with checksum check.
`timescale 1ns / 1ps
`default_nettype none
package fdcc_pkg;

   localparam int BUFFER_DEPTH_DEF = 32;
   localparam int MAX_ADDRESS_DEF  = 126;

   localparam logic [7:0] END_MARK  = 8'h7F;
   localparam logic       ADDR_FLAG = 1'b1;
   localparam logic [6:0] SUM_MARK  = 7'h7F;
   localparam int         OVERHEAD  = 5;

   // register indexes on the csr port
   localparam logic [1:0] CSR_SELF_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_MASTER_MODE  = 2'd1;
   localparam logic [1:0] CSR_PEER_ADDRESS = 2'd2;

   // result kinds
   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   // error codes
   localparam logic [2:0] ERR_DEST     = 3'd0;
   localparam logic [2:0] ERR_SOURCE   = 3'd1;
   localparam logic [2:0] ERR_CHECKSUM = 3'd2;
   localparam logic [2:0] ERR_OVERFLOW = 3'd3;
   localparam logic [2:0] ERR_SHORT    = 3'd4;
   localparam logic [2:0] ERR_NONE     = 3'd0;

endpackage
`default_nettype wire

// ===== hw/rtl/frame_deframer_checksum_check_core.sv =====
// Top level: framed byte receiver with address and 7-bit Fletcher checks.
// A non-marker byte is absorbed straight into the buffer. A closing marker streams
// the frame through the shared checksum adder and compare, then each delivered
// data byte takes a RAM read, then an output register load.
// Input takes one byte per cycle while the sequencer is idle; from a closing marker
// to the frame's end it stalls, as the single buffer read port serializes the work.
// Reset (synchronous, active high) clears fill count, sequencer and registers.
`timescale 1ns / 1ps
`default_nettype none
module frame_deframer_checksum_check_core
   import fdcc_pkg::*;
#(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
   parameter int MAX_ADDRESS  = MAX_ADDRESS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // input byte channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   // result channel
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_kind,
   output logic      [7:0] rsp_payload_byte,
   output logic      [2:0] rsp_fault_code,
   output logic            rsp_last,
   // register write channel
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_data
);

   localparam int IDX_W = $clog2(BUFFER_DEPTH);
   localparam int LEN_W = $clog2(BUFFER_DEPTH + 1);
   localparam logic [6:0] ADDR_RESET = 7'(MAX_ADDRESS);

   // sequencer codes
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CHK  = 3'd1;  // stream the frame, check header and checksum
   localparam logic [2:0] S_ERR  = 3'd2;  // hand out one error report
   localparam logic [2:0] S_DRD  = 3'd3;  // issue data byte read
   localparam logic [2:0] S_DWT  = 3'd4;  // present data byte

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] fill_ff, fill_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [IDX_W-1:0] rd_addr_ff, rd_addr_in;
   logic [IDX_W-1:0] pr_idx_ff, pr_idx_in;
   logic             rd_vld_ff, rd_vld_in;
   logic             iss_done_ff, iss_done_in;
   logic [6:0]       lo_ff, lo_in;
   logic [6:0]       hi_ff, hi_in;
   logic             mis_ff, mis_in;
   logic [2:0]       err_ff, err_in;
   logic [7:0]       reply_ff, reply_in;

   logic [6:0]       self_ff, self_in;
   logic             master_ff, master_in;
   logic [6:0]       peer_ff, peer_in;

   logic             out_vld_ff, out_vld_in;
   logic             out_kind_ff, out_kind_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic [2:0]       out_code_ff, out_code_in;
   logic             out_last_ff, out_last_in;

   logic             req_xfer;
   logic             out_free;
   logic             rd_en;
   logic [7:0]       rd_data;
   logic [LEN_W-1:0] new_len;
   logic [LEN_W-1:0] ckpos;
   logic [LEN_W-1:0] last_idx;
   logic [LEN_W-1:0] pr_idx_ext;
   logic [LEN_W-1:0] rd_addr_ext;
   logic [6:0]       lo_sum, hi_sum;
   logic [6:0]       lo_fix, hi_fix;

   // frame buffer, one write per accepted byte, at most one read per sequencer step
   fdcc_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr_en   (req_xfer),
      .wr_addr (fill_ff),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !out_vld_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign new_len     = LEN_W'(fill_ff) + LEN_W'(1);
   assign ckpos       = len_ff - LEN_W'(3);
   assign last_idx    = len_ff - LEN_W'(2);
   assign pr_idx_ext  = LEN_W'(pr_idx_ff);
   assign rd_addr_ext = LEN_W'(rd_addr_ff);

   // shared checksum unit: one byte per cycle through two 7-bit adders
   assign lo_sum = lo_ff + rd_data[6:0];
   assign hi_sum = hi_ff + lo_sum;
   // a marker value in a checksum byte is sent as zero
   assign lo_fix = (lo_ff == SUM_MARK) ? 7'd0 : lo_ff;
   assign hi_fix = (hi_ff == SUM_MARK) ? 7'd0 : hi_ff;

   always_comb begin
      rd_en = 1'b0;
      case (state_ff)
         S_CHK:   rd_en = !iss_done_ff;
         S_DRD:   rd_en = 1'b1;
         default: rd_en = 1'b0;
      endcase
   end

   // configuration registers
   always_comb begin
      self_in   = self_ff;
      master_in = master_ff;
      peer_in   = peer_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SELF_ADDRESS: self_in   = csr_data[6:0];
            CSR_MASTER_MODE:  master_in = csr_data[0];
            CSR_PEER_ADDRESS: peer_in   = csr_data[6:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      len_in      = len_ff;
      rd_addr_in  = rd_addr_ff;
      pr_idx_in   = rd_addr_ff;
      rd_vld_in   = rd_en && (state_ff == S_CHK);
      iss_done_in = iss_done_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mis_in      = mis_ff;
      err_in      = err_ff;
      reply_in    = reply_ff;
      out_vld_in  = out_vld_ff && rsp_stall;
      out_kind_in = out_kind_ff;
      out_byte_in = out_byte_ff;
      out_code_in = out_code_ff;
      out_last_in = out_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (req_rx_byte == END_MARK) begin
                  // marker closes the frame
                  fill_in     = '0;
                  len_in      = new_len;
                  rd_addr_in  = '0;
                  iss_done_in = 1'b0;
                  lo_in       = '0;
                  hi_in       = '0;
                  mis_in      = 1'b0;
                  if (new_len < LEN_W'(OVERHEAD)) begin
                     err_in   = ERR_SHORT;
                     state_in = S_ERR;
                  end else begin
                     state_in = S_CHK;
                  end
               end else if (new_len >= LEN_W'(BUFFER_DEPTH)) begin
                  // buffer full: drop the frame
                  fill_in  = '0;
                  err_in   = ERR_OVERFLOW;
                  state_in = S_ERR;
               end else begin
                  fill_in = IDX_W'(new_len);
               end
            end
         end

         S_CHK: begin
            // issue side: walk the buffer up to the checksum low byte
            if (rd_en) begin
               rd_addr_in = rd_addr_ff + IDX_W'(1);
               if (rd_addr_ext == last_idx) begin
                  iss_done_in = 1'b1;
               end
            end
            // process side: one byte per cycle, first failure wins
            if (rd_vld_ff) begin
               if (pr_idx_ext < ckpos) begin
                  lo_in = lo_sum;
                  hi_in = hi_sum;
               end
               if (pr_idx_ext == ckpos) begin
                  mis_in = (rd_data != {1'b0, hi_fix});
               end
               if (pr_idx_ext == LEN_W'(0)) begin
                  if (rd_data != {ADDR_FLAG, self_ff}) begin
                     err_in   = ERR_DEST;
                     state_in = S_ERR;
                  end
               end else if (pr_idx_ext == LEN_W'(1)) begin
                  if (master_ff) begin
                     if (rd_data != {1'b0, peer_ff}) begin
                        err_in   = ERR_SOURCE;
                        state_in = S_ERR;
                     end
                  end else begin
                     reply_in = rd_data;
                  end
               end else if (pr_idx_ext == last_idx) begin
                  if (mis_ff || (rd_data != {1'b0, lo_fix})) begin
                     err_in   = ERR_CHECKSUM;
                     state_in = S_ERR;
                  end else if (len_ff == LEN_W'(OVERHEAD)) begin
                     state_in = S_IDLE;
                  end else begin
                     rd_addr_in = IDX_W'(2);
                     state_in   = S_DRD;
                  end
               end
            end
         end

         S_ERR: begin
            if (out_free) begin
               out_vld_in  = 1'b1;
               out_kind_in = KIND_ERROR;
               out_byte_in = 8'h00;
               out_code_in = err_ff;
               out_last_in = 1'b1;
               state_in    = S_IDLE;
            end
         end

         S_DRD: begin
            state_in = S_DWT;
         end

         S_DWT: begin
            // hold the read data until the output register frees up
            if (out_free) begin
               out_vld_in  = 1'b1;
               out_kind_in = KIND_DATA;
               out_byte_in = rd_data;
               out_code_in = ERR_NONE;
               out_last_in = (rd_addr_ext == ckpos - LEN_W'(1));
               if (rd_addr_ext == ckpos - LEN_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  rd_addr_in = rd_addr_ff + IDX_W'(1);
                  state_in   = S_DRD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         fill_ff     <= '0;
         rd_vld_ff   <= 1'b0;
         iss_done_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         reply_ff    <= {1'b0, ADDR_RESET};
         self_ff     <= ADDR_RESET;
         master_ff   <= 1'b0;
         peer_ff     <= ADDR_RESET;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         rd_vld_ff   <= rd_vld_in;
         iss_done_ff <= iss_done_in;
         out_vld_ff  <= out_vld_in;
         reply_ff    <= reply_in;
         self_ff     <= self_in;
         master_ff   <= master_in;
         peer_ff     <= peer_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      rd_addr_ff  <= rd_addr_in;
      pr_idx_ff   <= pr_idx_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mis_ff      <= mis_in;
      err_ff      <= err_in;
      out_kind_ff <= out_kind_in;
      out_byte_ff <= out_byte_in;
      out_code_ff <= out_code_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_fault_code   = out_code_ff;
   assign rsp_last         = out_last_ff;

`ifndef SYNTHESIS
   // a frame under check always holds at least the fixed overhead
   a_chk_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK) |-> (len_ff >= LEN_W'(OVERHEAD)))
      else $error("frame check entered with a short frame");

   // data replay stays inside the data field
   a_data_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRD) |-> (rd_addr_ext >= LEN_W'(2) && rd_addr_ext < ckpos))
      else $error("data read outside the data field");

   // data results carry no error code
   a_data_code: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_kind_ff == KIND_DATA) |-> (out_code_ff == ERR_NONE))
      else $error("data result with nonzero error code");

   // error reports always close the item
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_kind_ff == KIND_ERROR) |-> (out_last_ff && out_byte_ff == 8'h00))
      else $error("malformed error report");

   // reply address only changes in slave mode while checking a frame
   a_reply_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_CHK || master_ff) |=> $stable(reply_ff))
      else $error("reply address changed outside slave frame check");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/fdcc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fdcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== test/tb_frame_deframer_checksum_check_core.sv =====
// Self-checking testbench for the framed byte receiver with 7-bit Fletcher check.
`timescale 1ns / 1ps
module tb_frame_deframer_checksum_check_core;
   import fdcc_pkg::*;

   localparam int DEPTH        = BUFFER_DEPTH_DEF;
   // room for a closing marker that replays a whole buffer
   localparam int DRAIN_CYCLES = 2 * (DEPTH - OVERHEAD) + DEPTH + 16;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_ITEMS = 130;

   typedef struct packed {
      logic       kind;
      logic [7:0] payload;
      logic [2:0] code;
      logic       last;
   } rsp_item_type;

   // ways to spoil the two checksum bytes of an otherwise good frame
   typedef enum int {DMG_NONE, DMG_HIGH, DMG_LOW, DMG_TOP_BIT} damage_type;

   // receiver back-pressure patterns
   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_RUNS} stall_mode_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic       rsp_kind;
   logic [7:0] rsp_payload_byte;
   logic [2:0] rsp_fault_code;
   logic       rsp_last;
   logic       csr_valid   = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index   = 2'd0;
   logic [7:0] csr_data    = 8'h00;

   frame_deframer_checksum_check_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_fault_code   (rsp_fault_code),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Receiver model: its own copy of the buffer, fill level and registers.
   // ------------------------------------------------------------------
   logic [7:0] frame_mem [DEPTH];
   int         fill_level;
   logic [6:0] self_addr;
   logic       master_on;
   logic [6:0] peer_addr;
   logic [7:0] reply_addr;
   rsp_item_type expected_q [$];

   int fail_count;
   int data_seen;
   int errors_seen;
   int bytes_sent;
   int settings_used;

   // one step of the mod-128 Fletcher sum, packed as {high, low}
   function automatic logic [13:0] fletcher_step(input logic [13:0] acc, input logic [7:0] b);
      logic [6:0] lo;
      logic [6:0] hi;
      lo = acc[6:0] + b[6:0];
      hi = acc[13:7] + lo;
      return {hi, lo};
   endfunction

   task automatic expect_error(input logic [2:0] code);
      expected_q.push_back('{KIND_ERROR, 8'h00, code, 1'b1});
   endtask

   // Check a closed frame: length first, then addresses, then the checksum.
   task automatic close_frame_model(input int len);
      logic [13:0] acc;
      logic [6:0]  lo;
      logic [6:0]  hi;
      int          ckpos;
      int          ndata;
      acc = '0;
      if (len < OVERHEAD) begin
         expect_error(ERR_SHORT);
      end else if (frame_mem[0] != {ADDR_FLAG, self_addr}) begin
         expect_error(ERR_DEST);
      end else if (master_on && frame_mem[1] != {1'b0, peer_addr}) begin
         expect_error(ERR_SOURCE);
      end else begin
         // slave side records the source as soon as the destination matched
         if (!master_on) begin
            reply_addr = frame_mem[1];
         end
         ckpos = len - 3;
         for (int i = 0; i < ckpos; i++) begin
            acc = fletcher_step(acc, frame_mem[i]);
         end
         // a sum that would look like the end marker is sent as zero
         lo = (acc[6:0] == SUM_MARK) ? 7'h00 : acc[6:0];
         hi = (acc[13:7] == SUM_MARK) ? 7'h00 : acc[13:7];
         if (frame_mem[ckpos] != {1'b0, hi} || frame_mem[ckpos + 1] != {1'b0, lo}) begin
            expect_error(ERR_CHECKSUM);
         end else begin
            ndata = len - OVERHEAD;
            for (int i = 0; i < ndata; i++) begin
               expected_q.push_back('{KIND_DATA, frame_mem[2 + i], ERR_NONE, (i + 1 == ndata)});
            end
         end
      end
   endtask

   // Store one accepted byte; a marker closes the frame, a full buffer overflows.
   task automatic absorb_byte(input logic [7:0] b);
      int len;
      if (fill_level >= DEPTH) begin
         fill_level = 0;
      end
      frame_mem[fill_level] = b;
      len = fill_level + 1;
      if (b == END_MARK) begin
         fill_level = 0;
         close_frame_model(len);
      end else if (len >= DEPTH) begin
         fill_level = 0;
         expect_error(ERR_OVERFLOW);
      end else begin
         fill_level = len;
      end
   endtask

   // ------------------------------------------------------------------
   // Sender: bursts of random length with random gaps between them.
   // ------------------------------------------------------------------
   int burst_left;
   bit steady_feed;

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (!steady_feed && burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
         // drop valid only for a real gap so valid never dips within one step
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      // hold the byte until the edge that takes the transfer
      do @(posedge clock); while (req_stall);
      absorb_byte(b);
      bytes_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == END_MARK);
      return b;
   endfunction

   logic [7:0] data_q [$];

   task automatic fill_data(input int n);
      data_q.delete();
      repeat (n) data_q.push_back(plain_byte());
   endtask

   function automatic logic [13:0] frame_sum(input logic [7:0] dest, input logic [7:0] src);
      logic [13:0] acc;
      acc = fletcher_step(14'h0, dest);
      acc = fletcher_step(acc, src);
      foreach (data_q[i]) acc = fletcher_step(acc, data_q[i]);
      return acc;
   endfunction

   // Send destination, source, data_q, both checksum bytes and the marker.
   task automatic send_frame(input logic [7:0] dest, input logic [7:0] src,
                             input damage_type damage);
      logic [13:0] acc;
      logic [7:0]  hi_b;
      logic [7:0]  lo_b;
      acc  = frame_sum(dest, src);
      hi_b = (acc[13:7] == SUM_MARK) ? 8'h00 : {1'b0, acc[13:7]};
      lo_b = (acc[6:0] == SUM_MARK) ? 8'h00 : {1'b0, acc[6:0]};
      // spoil without ever producing the marker value
      case (damage)
         DMG_HIGH: begin
            hi_b = (hi_b == 8'h00) ? 8'h01 : hi_b - 8'h01;
         end
         DMG_LOW: begin
            lo_b = (lo_b == 8'h00) ? 8'h01 : lo_b - 8'h01;
         end
         DMG_TOP_BIT: begin
            hi_b[7] = 1'b1;
         end
         default: begin
         end
      endcase
      send_byte(dest);
      send_byte(src);
      foreach (data_q[i]) send_byte(data_q[i]);
      send_byte(hi_b);
      send_byte(lo_b);
      send_byte(END_MARK);
   endtask

   // Drain: every expected result back, then room for a frame that gives none.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   // Write all three registers back to back while the receiver is idle.
   task automatic write_config(input logic [7:0] self_v, input logic [7:0] master_v,
                               input logic [7:0] peer_v);
      logic [1:0] idx [3];
      logic [7:0] val [3];
      idx = '{CSR_SELF_ADDRESS, CSR_MASTER_MODE, CSR_PEER_ADDRESS};
      val = '{self_v, master_v, peer_v};
      wait_idle();
      csr_valid <= 1'b1;
      for (int i = 0; i < 3; i++) begin
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
         // only the register width is kept
         case (idx[i])
            CSR_SELF_ADDRESS: begin
               self_addr = val[i][6:0];
            end
            CSR_MASTER_MODE: begin
               master_on = val[i][0];
            end
            CSR_PEER_ADDRESS: begin
               peer_addr = val[i][6:0];
            end
            default: begin
            end
         endcase
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // ------------------------------------------------------------------
   // Receiver back-pressure: a pattern that is redrawn after each random span.
   // ------------------------------------------------------------------
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_span = 0;
   int             stall_run  = 0;

   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_span <= $urandom_range(40, 300);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_LIGHT: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         STALL_HALF: begin
            rsp_stall <= 1'($urandom_range(0, 1));
         end
         default: begin
            // alternate stalled and open stretches of random length
            if (stall_run == 0) begin
               rsp_stall <= ~rsp_stall;
               stall_run <= $urandom_range(1, 12);
            end else begin
               stall_run <= stall_run - 1;
            end
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Result check: compare each transfer with the oldest expectation.
   // ------------------------------------------------------------------
   task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("%0t ns: result with nothing expected, kind %0d byte 0x%0h code %0d last %0d",
                     $time, rsp_kind, rsp_payload_byte, rsp_fault_code, rsp_last);
            fail_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_kind !== want.kind) report_field("kind", 8'(want.kind), 8'(rsp_kind));
            if (rsp_payload_byte !== want.payload) begin
               report_field("payload_byte", want.payload, rsp_payload_byte);
            end
            if (rsp_fault_code !== want.code) begin
               report_field("fault_code", 8'(want.code), 8'(rsp_fault_code));
            end
            if (rsp_last !== want.last) report_field("last", 8'(want.last), 8'(rsp_last));
         end
         if (rsp_kind == KIND_DATA) begin
            data_seen++;
         end else begin
            errors_seen++;
         end
      end
   end

   // Watchdog: a stuck handshake ends the run here.
   int unsigned cycle_count = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_frame_deframer_checksum_check_core failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset values: self 126 in slave mode, so frames go to 0xFE.
   task automatic test_power_on_defaults();
      fill_data(3);
      send_frame(8'hFE, 8'h05, DMG_NONE);
      // no data bytes: a good frame that delivers nothing
      fill_data(0);
      send_frame(8'hFE, 8'hFE, DMG_NONE);
   endtask

   // Marker alone, two bytes and four bytes: all too short.
   task automatic test_short_frames();
      send_byte(END_MARK);
      send_byte(8'hFE);
      send_byte(END_MARK);
      send_byte(8'hFE);
      send_byte(8'h01);
      send_byte(8'h00);
      send_byte(END_MARK);
   endtask

   task automatic test_checksum_faults();
      fill_data(2);
      send_frame(8'hFE, 8'h10, DMG_HIGH);
      fill_data(2);
      send_frame(8'hFE, 8'h10, DMG_LOW);
      fill_data(1);
      send_frame(8'hFE, 8'h10, DMG_TOP_BIT);
   endtask

   // Sums that land on the marker value are carried as zero.
   task automatic test_checksum_wrap();
      logic [13:0] acc;
      do begin
         fill_data(2);
         acc = frame_sum(8'hFE, 8'h21);
      end while (acc[6:0] != SUM_MARK);
      send_frame(8'hFE, 8'h21, DMG_NONE);
      do begin
         fill_data(2);
         acc = frame_sum(8'hFE, 8'h21);
      end while (acc[13:7] != SUM_MARK);
      send_frame(8'hFE, 8'h21, DMG_NONE);
   endtask

   task automatic test_address_checks();
      // destination without the flag bit
      fill_data(2);
      send_frame(8'h7E, 8'h01, DMG_NONE);
      // master: matching source, wrong source, wrong destination
      write_config(8'd5, 8'd1, 8'd9);
      fill_data(2);
      send_frame(8'h85, 8'h09, DMG_NONE);
      send_frame(8'h85, 8'h0A, DMG_NONE);
      send_frame(8'h86, 8'h09, DMG_NONE);
      // lowest addresses
      write_config(8'h00, 8'h01, 8'h00);
      fill_data(1);
      send_frame(8'h80, 8'h00, DMG_NONE);
      // address 127 taken as written; a peer of 127 looks like the marker
      write_config(8'hFF, 8'hFF, 8'h7F);
      send_byte(8'hFF);
      send_byte(END_MARK);
      write_config(8'h7F, 8'hFE, 8'hFE);
      fill_data(2);
      send_frame(8'hFF, 8'hC3, DMG_NONE);
   endtask

   task automatic test_buffer_limits();
      // largest frame that fits: every data byte delivered
      fill_data(DEPTH - OVERHEAD);
      send_frame({ADDR_FLAG, self_addr}, 8'h33, DMG_NONE);
      // a full buffer without a marker overflows, then the marker is short
      fill_data(DEPTH);
      foreach (data_q[i]) send_byte(data_q[i]);
      send_byte(END_MARK);
      // and the next frame gets through again
      fill_data(3);
      send_frame({ADDR_FLAG, self_addr}, 8'h44, DMG_NONE);
   endtask

   // Mostly well-formed frames with random content, the rest broken or noise.
   task automatic test_random_traffic();
      int         pick;
      int         ndata;
      int         phase_end;
      logic [7:0] src;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_config(8'h00, 8'h01, 8'h00);
            end
            1: begin
               write_config(8'h7F, 8'h00, 8'h7E);
            end
            2: begin
               write_config(8'($urandom_range(0, 255)), 8'h01, 8'($urandom_range(0, 255)));
            end
            default: begin
               write_config(8'($urandom_range(0, 126)), 8'($urandom_range(0, 1)),
                            8'($urandom_range(0, 126)));
            end
         endcase
         // one phase runs with no sender gaps at all
         steady_feed = (phase == 1);
         phase_end = bytes_sent + RANDOM_ITEMS / 4;
         while (bytes_sent < phase_end) begin
            pick  = $urandom_range(0, 99);
            src   = master_on ? {1'b0, peer_addr} : plain_byte();
            ndata = ($urandom_range(0, 9) == 0) ? $urandom_range(20, DEPTH - OVERHEAD)
                                               : $urandom_range(0, 6);
            fill_data(ndata);
            if (pick < 70) begin
               send_frame({ADDR_FLAG, self_addr}, src, DMG_NONE);
            end else if (pick < 78) begin
               send_frame({ADDR_FLAG, self_addr}, src, damage_type'($urandom_range(1, 3)));
            end else if (pick < 84) begin
               send_frame(plain_byte(), src, DMG_NONE);
            end else if (pick < 89) begin
               send_frame({ADDR_FLAG, self_addr}, plain_byte(), DMG_NONE);
            end else if (pick < 93) begin
               repeat ($urandom_range(0, 3)) send_byte(plain_byte());
               send_byte(END_MARK);
            end else if (pick < 96) begin
               fill_data($urandom_range(DEPTH, DEPTH + 8));
               foreach (data_q[i]) send_byte(data_q[i]);
            end else begin
               repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
         end
      end
      steady_feed = 1'b0;
   endtask

   initial begin
      fill_level    = 0;
      self_addr     = 7'(MAX_ADDRESS_DEF);
      master_on     = 1'b0;
      peer_addr     = 7'(MAX_ADDRESS_DEF);
      reply_addr    = 8'(MAX_ADDRESS_DEF);
      fail_count    = 0;
      data_seen     = 0;
      errors_seen   = 0;
      bytes_sent    = 0;
      settings_used = 1;
      burst_left    = 0;
      steady_feed   = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_power_on_defaults();
      test_short_frames();
      test_checksum_faults();
      test_checksum_wrap();
      test_address_checks();
      test_buffer_limits();
      test_random_traffic();

      wait_idle();
      if (expected_q.size() != 0) begin
         $display("%0t ns: %0d expected results never arrived", $time, expected_q.size());
         fail_count++;
      end

      $display("Sent %0d bytes under %0d register settings.", bytes_sent, settings_used);
      $display("Checked %0d delivered data bytes and %0d error reports.", data_seen, errors_seen);
      if (fail_count == 0) begin
         $display("tb_frame_deframer_checksum_check_core passed");
      end else begin
         $display("tb_frame_deframer_checksum_check_core failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/fdcc_pkg.sv
hw/rtl/fdcc_ram.sv
hw/rtl/frame_deframer_checksum_check_core.sv
test/tb_frame_deframer_checksum_check_core.sv
